@@ src/blm_pkg.sv @@
// ----------------------------------------------------------------------------
// blm_pkg
// Shared types and codes for the bounded ordered list and its cells.
// ----------------------------------------------------------------------------
package blm_pkg;

    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int LIMIT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT_FRONT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND_BACK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE       = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL_REFUSED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY_REFUSED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND     = 2'd3;

    // What a cell takes into its entry register this cycle.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_FROM_LEFT  = 2'd1,
        CELL_FROM_RIGHT = 2'd2,
        CELL_LOAD       = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     occupied;
        logic     capture;
    } cell_ctrl_t;

endpackage

@@ src/blm_cell.sv @@
// ----------------------------------------------------------------------------
// blm_cell
// One list entry: holds a value, compares it with a searched value and
// shifts toward either neighbor.
// ----------------------------------------------------------------------------
module blm_cell
    import blm_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic [VALUE_W-1:0] left_data,
    input  logic [VALUE_W-1:0] right_data,
    input  logic [VALUE_W-1:0] load_data,
    input  logic [VALUE_W-1:0] cmp_data,
    input  logic               seen_in,
    output logic [VALUE_W-1:0] data,
    output logic               seen_out
);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               match_reg;
    logic               match_next;

    always_comb
    begin
        case (ctrl.op)
            CELL_FROM_LEFT:  data_next = left_data;
            CELL_FROM_RIGHT: data_next = right_data;
            CELL_LOAD:       data_next = load_data;
            default:         data_next = data_reg;
        endcase
    end

    assign match_next = ctrl.capture ? (ctrl.occupied && (data_reg == cmp_data)) : match_reg;

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    // A match here or anywhere closer to the front marks this cell as part
    // of the tail that closes the gap.
    assign seen_out = seen_in | match_reg;
    assign data     = data_reg;

endmodule

@@ src/bounded_ordered_list.sv @@
// ----------------------------------------------------------------------------
// bounded_ordered_list
// Ordered list of signed 32-bit values in a row of shifting cells.
// ----------------------------------------------------------------------------
// For each request, on the accepting edge every cell compares its entry
// with the request value; in the following cycle (busy high) the cells
// shift or load and the count is updated. The result strobe done is high
// in the cycle after that, for one cycle only, and the receiver cannot
// stall it; busy is already low then, so a new request may be accepted at
// the edge that ends the strobe, and none is accepted while busy is high.
// The first-match search on remove ripples one bit through the whole row of
// DEPTH cells, which sets the clock period for large depths. capacity_limit
// is to be written through cfg_we/cfg_data only while idle, which the block
// does not enforce; 0 acts as 1 and values above DEPTH act as DEPTH.
module bounded_ordered_list
    import blm_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ACTION_W-1:0]       action,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      cfg_we,
    input  logic [LIMIT_W-1:0]        cfg_data,
    output logic                      done,
    output logic [STATUS_W-1:0]       status,
    output logic [COUNT_W-1:0]        entry_count,
    output logic                      list_empty,
    output logic                      list_full,
    output logic signed [VALUE_W-1:0] front_value,
    output logic signed [VALUE_W-1:0] back_value
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic                 done_reg;
    logic                 done_next;
    logic [ACTION_W-1:0]  action_reg;
    logic [VALUE_W-1:0]   value_reg;

    logic                 accept;
    logic [LW-1:0]        eff_limit;
    logic                 is_full;
    logic                 found;
    logic                 do_insert;
    logic                 do_append;
    logic                 do_remove;

    logic [VALUE_W-1:0]   cell_data [DEPTH];
    logic                 seen      [DEPTH+1];
    cell_ctrl_t           cell_ctrl [DEPTH];
    logic [VALUE_W-1:0]   back_sel;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_EXEC);

    always_comb
    begin
        if (limit_reg == '0)
            eff_limit = LW'(1);
        else if (LW'(limit_reg) > DEPTH_L)
            eff_limit = DEPTH_L;
        else
            eff_limit = LW'(limit_reg);
    end

    assign is_full = (LW'(count_reg) >= eff_limit);
    assign found   = seen[DEPTH];

    assign do_insert = busy && (action_reg == ACT_INSERT_FRONT) && !is_full;
    assign do_append = busy && (action_reg == ACT_APPEND_BACK) && !is_full;
    assign do_remove = busy && (action_reg == ACT_REMOVE) && (count_reg != '0) && found;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = ST_DONE;
                case (action_reg)
                    ACT_INSERT_FRONT, ACT_APPEND_BACK:
                    begin
                        if (is_full)
                            status_next = ST_FULL_REFUSED;
                        else
                            count_next = count_reg + CW'(1);
                    end
                    ACT_REMOVE:
                    begin
                        if (count_reg == '0)
                            status_next = ST_EMPTY_REFUSED;
                        else if (!found)
                            status_next = ST_NOT_FOUND;
                        else
                            count_next = count_reg - CW'(1);
                    end
                    default:
                    begin
                        status_next = ST_DONE;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            limit_reg  <= LIMIT_W'(16);
            count_reg  <= '0;
            status_reg <= ST_DONE;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            done_reg   <= done_next;
            if (cfg_we)
                limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            value_reg  <= value;
        end
    end

    assign seen[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [VALUE_W-1:0] left_d;
            logic [VALUE_W-1:0] right_d;

            if (gi == 0)
            begin : g_first
                assign left_d = value_reg;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end

            always_comb
            begin
                cell_ctrl[gi].capture  = accept;
                cell_ctrl[gi].occupied = (CW'(gi) < count_reg);
                cell_ctrl[gi].op       = CELL_HOLD;
                if (do_insert)
                    cell_ctrl[gi].op = (gi == 0) ? CELL_LOAD : CELL_FROM_LEFT;
                else if (do_append && (CW'(gi) == count_reg))
                    cell_ctrl[gi].op = CELL_LOAD;
                else if (do_remove && seen[gi+1])
                    cell_ctrl[gi].op = CELL_FROM_RIGHT;
            end

            blm_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[gi]),
                .left_data  (left_d),
                .right_data (right_d),
                .load_data  (value_reg),
                .cmp_data   (value),
                .seen_in    (seen[gi]),
                .data       (cell_data[gi]),
                .seen_out   (seen[gi+1])
            );
        end
    endgenerate

    // The last occupied cell is picked by an OR over one-hot selects.
    always_comb
    begin
        back_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CW'(i) == count_reg - CW'(1))
                back_sel = back_sel | cell_data[i];
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = COUNT_W'(count_reg);
    assign list_empty  = (count_reg == '0);
    assign list_full   = is_full;
    assign front_value = (count_reg == '0) ? '0 : cell_data[0];
    assign back_value  = (count_reg == '0) ? '0 : back_sel;

endmodule

@@ bench/list_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_checker
// Watches the request, configuration and result ports of the bounded ordered
// list. It keeps its own copy of the list, predicts the result of every
// accepted request and compares each strobed result with the oldest one.
// ----------------------------------------------------------------------------
module list_checker
    import blm_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [ACTION_W-1:0]       action,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      cfg_we,
    input  logic [LIMIT_W-1:0]        cfg_data,
    input  logic                      done,
    input  logic [STATUS_W-1:0]       status,
    input  logic [COUNT_W-1:0]        entry_count,
    input  logic                      list_empty,
    input  logic                      list_full,
    input  logic signed [VALUE_W-1:0] front_value,
    input  logic signed [VALUE_W-1:0] back_value,
    output int                        mismatch_count,
    output int                        outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                empty;
        logic                full;
        logic [VALUE_W-1:0]  front;
        logic [VALUE_W-1:0]  back;
    } list_result_t;

    logic [VALUE_W-1:0] shadow_entries [DEPTH];
    int                 shadow_total;
    logic [LIMIT_W-1:0] shadow_limit;
    list_result_t       expected_results [$];
    list_result_t       observed;
    list_result_t       predicted;
    int                 errors;

    function automatic int effective_limit(input logic [LIMIT_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > DEPTH)
            return DEPTH;
        return int'(raw);
    endfunction

    // Updates the shadow list for one request and returns the result it causes.
    task automatic apply_request(input logic [ACTION_W-1:0] act,
                                 input logic [VALUE_W-1:0] val,
                                 output list_result_t res);
        int   lim;
        int   pos;
        int   i;
        logic at_limit;
        logic found;
        lim = effective_limit(shadow_limit);
        at_limit = (shadow_total >= lim);
        res.status = ST_DONE;
        case (act)
            ACT_INSERT_FRONT:
            begin
                if (at_limit)
                    res.status = ST_FULL_REFUSED;
                else
                begin
                    for (i = shadow_total; i > 0; i--)
                        shadow_entries[i] = shadow_entries[i - 1];
                    shadow_entries[0] = val;
                    shadow_total++;
                end
            end
            ACT_APPEND_BACK:
            begin
                if (at_limit)
                    res.status = ST_FULL_REFUSED;
                else
                begin
                    shadow_entries[shadow_total] = val;
                    shadow_total++;
                end
            end
            ACT_REMOVE:
            begin
                if (shadow_total == 0)
                    res.status = ST_EMPTY_REFUSED;
                else
                begin
                    found = 1'b0;
                    pos = 0;
                    for (i = 0; i < shadow_total && !found; i++)
                    begin
                        if (shadow_entries[i] == val)
                        begin
                            pos = i;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        res.status = ST_NOT_FOUND;
                    else
                    begin
                        for (i = pos; i + 1 < shadow_total; i++)
                            shadow_entries[i] = shadow_entries[i + 1];
                        shadow_total--;
                    end
                end
            end
            default:
            begin
                // The spare action code leaves the list as it is.
            end
        endcase
        res.count = COUNT_W'(shadow_total);
        res.empty = (shadow_total == 0);
        res.full  = (shadow_total >= lim);
        res.front = (shadow_total == 0) ? '0 : shadow_entries[0];
        res.back  = (shadow_total == 0) ? '0 : shadow_entries[shadow_total - 1];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_total = 0;
            shadow_limit = LIMIT_W'(16);
            expected_results.delete();
            errors = 0;
            mismatch_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            // A result leaving and a new request arriving may share one edge; the
            // result always belongs to an older request, so order does not matter.
            if (done)
            begin
                observed = {status, entry_count, list_empty, list_full,
                            front_value, back_value};
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: result with no request pending: %p", $time, observed);
                end
                else
                begin
                    predicted = expected_results.pop_front();
                    if (observed !== predicted)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("%0t: result mismatch, expected %p, got %p",
                                     $time, predicted, observed);
                    end
                end
            end
            if (cfg_we)
                shadow_limit = cfg_data;
            if (start && !busy)
            begin
                apply_request(action, value, predicted);
                expected_results.push_back(predicted);
            end
            mismatch_count <= errors;
            outstanding <= expected_results.size();
        end
    end

endmodule

@@ bench/bounded_ordered_list_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_tb
// Drives insert, append and remove requests into the bounded ordered list
// under a range of capacity limits, with random gaps between requests, and
// reports the verdict of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module bounded_ordered_list_tb
    import blm_pkg::*;
();

    localparam int DEPTH           = 16;
    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int CALM_PHASES     = 2;
    localparam int POOL_SIZE       = 8;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 1000;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [VALUE_W-1:0]  VAL_MIN    = 32'h8000_0000;
    localparam logic [VALUE_W-1:0]  VAL_MAX    = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0]  VAL_ONES   = 32'hFFFF_FFFF;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [ACTION_W-1:0]       action = ACT_INSERT_FRONT;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      cfg_we = 1'b0;
    logic [LIMIT_W-1:0]        cfg_data = '0;
    logic                      done;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        entry_count;
    logic                      list_empty;
    logic                      list_full;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;

    int mismatch_count;
    int outstanding;
    int stall_cycles = 0;

    logic [VALUE_W-1:0]  value_pool [POOL_SIZE];
    logic [LIMIT_W-1:0]  phase_limit;
    logic [ACTION_W-1:0] next_action;
    logic [VALUE_W-1:0]  next_value;
    int                  fill_bias;
    int                  roll;

    always #(CLK_PERIOD / 2) clk = ~clk;

    bounded_ordered_list #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .value       (value),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status),
        .entry_count (entry_count),
        .list_empty  (list_empty),
        .list_full   (list_full),
        .front_value (front_value),
        .back_value  (back_value)
    );

    list_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .value          (value),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .done           (done),
        .status         (status),
        .entry_count    (entry_count),
        .list_empty     (list_empty),
        .list_full      (list_full),
        .front_value    (front_value),
        .back_value     (back_value),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Ends the run when neither a request nor a result moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Presents one request and returns at the edge that accepts it.
    task automatic issue_request(input logic [ACTION_W-1:0] act,
                                 input logic [VALUE_W-1:0] val);
        start  <= 1'b1;
        action <= act;
        value  <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_burst(input int cycles);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset limit: empty list, extremes, duplicates,
        // removal at the front, middle and back, and the spare action code.
        issue_request(ACT_REMOVE, 32'd42);
        issue_request(ACT_UNUSED, 32'd0);
        issue_request(ACT_INSERT_FRONT, VAL_MIN);
        issue_request(ACT_APPEND_BACK, VAL_MAX);
        issue_request(ACT_INSERT_FRONT, 32'd5);
        issue_request(ACT_APPEND_BACK, 32'd5);
        issue_request(ACT_APPEND_BACK, 32'd7);
        issue_request(ACT_REMOVE, 32'd5);
        issue_request(ACT_REMOVE, 32'd99);
        issue_request(ACT_REMOVE, VAL_MAX);
        issue_request(ACT_REMOVE, 32'd7);
        issue_request(ACT_UNUSED, VAL_ONES);
        issue_request(ACT_REMOVE, VAL_MIN);
        issue_request(ACT_REMOVE, 32'd5);

        // A small limit: fill up, then both inserts are refused.
        write_limit(LIMIT_W'(2));
        issue_request(ACT_APPEND_BACK, 32'd1);
        issue_request(ACT_APPEND_BACK, 32'd2);
        issue_request(ACT_INSERT_FRONT, 32'd3);
        issue_request(ACT_APPEND_BACK, 32'd4);

        // Limit lowered below the count: entries stay, removes still work.
        write_limit(LIMIT_W'(1));
        issue_request(ACT_INSERT_FRONT, 32'd6);
        issue_request(ACT_REMOVE, 32'd1);
        issue_request(ACT_REMOVE, 32'd2);

        // A limit of zero behaves as one.
        write_limit(LIMIT_W'(0));
        issue_request(ACT_APPEND_BACK, VAL_ONES);
        issue_request(ACT_APPEND_BACK, 32'd1);
        issue_request(ACT_REMOVE, VAL_ONES);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       phase_limit = LIMIT_W'(16);
                1:       phase_limit = LIMIT_W'(31);
                2:       phase_limit = LIMIT_W'(1);
                3:       phase_limit = LIMIT_W'(0);
                4:       phase_limit = LIMIT_W'(3);
                default: phase_limit = LIMIT_W'($urandom_range(0, 31));
            endcase
            write_limit(phase_limit);

            // A small pool of values makes duplicates and successful removes common.
            for (int k = 0; k < POOL_SIZE; k++)
                value_pool[k] = $urandom;
            if ($urandom_range(0, 1) == 0)
            begin
                value_pool[0] = VAL_MIN;
                value_pool[1] = VAL_MAX;
            end
            fill_bias = $urandom_range(30, 70);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    next_action = ACT_UNUSED;
                else if (roll < 3 + fill_bias)
                    next_action = ($urandom_range(0, 1) == 0) ? ACT_INSERT_FRONT
                                                               : ACT_APPEND_BACK;
                else
                    next_action = ACT_REMOVE;
                if ($urandom_range(0, 99) < 75)
                    next_value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    next_value = $urandom;
                issue_request(next_action, next_value);
                if (phase < RANDOM_PHASES - CALM_PHASES && $urandom_range(0, 3) == 0)
                    idle_burst($urandom_range(1, 5));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
